[hw/rtl/resource_hazard_edge_tracker_core_defines.svh]
// assertion macros for the resource hazard edge tracker
// used by resource_hazard_edge_tracker_core; expects clock and reset in scope
`ifndef RESOURCE_HAZARD_EDGE_TRACKER_CORE_DEFINES_SVH
`define RESOURCE_HAZARD_EDGE_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTH
`define RHET_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rhet assertion failed");
`define RHET_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rhet assertion failed");
`else
`define RHET_ASSERT_IMPL(lbl, ante, cons)
`define RHET_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/rhet_pkg.sv]
// shared constants, codes and types of the resource hazard edge tracker
// no dependencies
package rhet_pkg;

   localparam int NUM_RESOURCES = 64;
   localparam int MAX_READERS   = 16;
   localparam int MAX_JOBS      = 1024;

   localparam int JOB_W    = $clog2(MAX_JOBS);
   localparam int RES_W    = $clog2(NUM_RESOURCES);
   localparam int RIDX_W   = $clog2(MAX_READERS);
   localparam int CNT_W    = $clog2(MAX_READERS + 1);
   localparam int LIST_AW  = RES_W + RIDX_W;
   localparam int ACTION_W = 2;

   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ORDER = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

   typedef logic [JOB_W-1:0]   job_type;
   typedef logic [RES_W-1:0]   res_type;
   typedef logic [RIDX_W-1:0]  ridx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [LIST_AW-1:0] list_addr_type;

   localparam cnt_type CNT_FULL = cnt_type'(MAX_READERS);

   // write command into the per-resource table
   typedef struct packed {
      logic    clear;
      logic    lw_we;
      logic    cnt_we;
      res_type addr;
      job_type lw;
      cnt_type cnt;
   } tbl_wr_type;

   // registered read data of the per-resource table
   typedef struct packed {
      logic    wv;
      job_type lw;
      cnt_type cnt;
   } tbl_rd_type;

endpackage

[hw/rtl/resource_hazard_edge_tracker_core.sv]
// resource hazard edge tracker, top level: sequencer, reader walk and result register
// depends on rhet_pkg, rhet_res_table, rhet_reader_ram and the defines header
//
// usage
//  req channel: one beat per declaration (action, job, resource, other job);
//    read, write, order after another job, or clear the whole table
//  rsp channel: one or more beats per request, the final one flagged by rsp_last;
//    a beat carries a dependency edge (edge_from before edge_to) or, when the
//    request caused none, a single beat with rsp_edge_valid low
//  order: the request is captured, its table entry and first reader slot are
//    read, then a beat is loaded into the result register; a write with stored
//    readers first walks its reader list, giving beats from S_WALK and S_FIN
//  throughput: one request at a time; req_ready is high only while idle;
//    the walk over the reader list memory looks at one reader per cycle
//    unless the result register stalls, over at most 16 stored readers
//  reset: empties every reader list and forgets every writer at once through
//    valid bits; no clearing pass, the block is ready in the first idle cycle
//  rsp stall: the result register holds its beat; the walk keeps one edge
//    pending and waits, so nothing is lost or repeated
module resource_hazard_edge_tracker_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rhet_pkg::ACTION_W-1:0]         req_action,
   input  logic [rhet_pkg::JOB_W-1:0]            req_job_index,
   input  logic [rhet_pkg::RES_W-1:0]            req_resource_id,
   input  logic [rhet_pkg::JOB_W-1:0]            req_other_job,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_edge_valid,
   output logic [rhet_pkg::JOB_W-1:0]            rsp_edge_from,
   output logic [rhet_pkg::JOB_W-1:0]            rsp_edge_to,
   output logic                                  rsp_reader_overflow,
   output logic                                  rsp_last
);

`include "resource_hazard_edge_tracker_core_defines.svh"

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request beat
   localparam logic [1:0] S_LOOK = 2'd1;  // table entry available, decide
   localparam logic [1:0] S_WALK = 2'd2;  // stepping through stored readers
   localparam logic [1:0] S_FIN  = 2'd3;  // flush pending edge, record writer

   logic [1:0] state_ff, state_in;

   // captured request
   logic [rhet_pkg::ACTION_W-1:0] act_ff, act_in;
   rhet_pkg::job_type             job_ff, job_in;
   rhet_pkg::res_type             res_ff, res_in;
   rhet_pkg::job_type             other_ff, other_in;

   // walk state: reader count, slot index and one held-back edge source
   rhet_pkg::cnt_type  cnt_ff, cnt_in;
   rhet_pkg::ridx_type idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   rhet_pkg::job_type  pend_job_ff, pend_job_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ev_ff, rsp_ev_in;
   rhet_pkg::job_type rsp_from_ff, rsp_from_in;
   rhet_pkg::job_type rsp_to_ff, rsp_to_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff, rsp_last_in;

   // table and list ports
   rhet_pkg::res_type       tbl_raddr;
   rhet_pkg::tbl_wr_type    tbl_wr;
   rhet_pkg::tbl_rd_type    tbl_rd;
   logic                    list_we;
   rhet_pkg::list_addr_type list_waddr;
   rhet_pkg::list_addr_type list_raddr;
   rhet_pkg::job_type       list_rdata;

   logic out_load;
   logic slot_free;
   logic walk_last;
   logic self_edge;

   rhet_res_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (tbl_raddr),
      .wr      (tbl_wr),
      .rd      (tbl_rd)
   );

   rhet_reader_ram u_list (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (job_ff),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   // the result register can take a beat when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign walk_last = (rhet_pkg::cnt_type'(idx_ff) + rhet_pkg::cnt_type'(1)) == cnt_ff;
   assign self_edge = (list_rdata == job_ff);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      job_in        = job_ff;
      res_in        = res_ff;
      other_in      = other_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_job_in   = pend_job_ff;

      out_load    = 1'b0;
      rsp_ev_in   = 1'b0;
      rsp_from_in = '0;
      rsp_to_in   = '0;
      rsp_ovf_in  = 1'b0;
      rsp_last_in = 1'b1;

      tbl_raddr  = res_ff;
      tbl_wr     = '0;
      tbl_wr.addr = res_ff;
      list_we    = 1'b0;
      list_waddr = {res_ff, tbl_rd.cnt[rhet_pkg::RIDX_W-1:0]};
      list_raddr = {res_ff, idx_ff};

      unique case (state_ff)
         S_IDLE: begin
            // read table and first list slot of the incoming resource
            tbl_raddr  = req_resource_id;
            list_raddr = {req_resource_id, rhet_pkg::ridx_type'(0)};
            if (req_valid) begin
               act_in   = req_action;
               job_in   = req_job_index;
               res_in   = req_resource_id;
               other_in = req_other_job;
               idx_in   = '0;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (act_ff == rhet_pkg::ACT_WRITE && tbl_rd.cnt != '0) begin
               // slot 0 is already on the list read port
               cnt_in        = tbl_rd.cnt;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = S_WALK;
            end else if (slot_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               unique case (act_ff)
                  rhet_pkg::ACT_READ: begin
                     if (tbl_rd.wv && tbl_rd.lw != job_ff) begin
                        rsp_ev_in   = 1'b1;
                        rsp_from_in = tbl_rd.lw;
                        rsp_to_in   = job_ff;
                     end
                     if (tbl_rd.cnt == rhet_pkg::CNT_FULL) begin
                        // list full, reader dropped
                        rsp_ovf_in = 1'b1;
                     end else begin
                        list_we       = 1'b1;
                        tbl_wr.cnt_we = 1'b1;
                        tbl_wr.cnt    = tbl_rd.cnt + rhet_pkg::cnt_type'(1);
                     end
                  end
                  rhet_pkg::ACT_WRITE: begin
                     // no readers: depend on the previous writer
                     if (tbl_rd.wv && tbl_rd.lw != job_ff) begin
                        rsp_ev_in   = 1'b1;
                        rsp_from_in = tbl_rd.lw;
                        rsp_to_in   = job_ff;
                     end
                     tbl_wr.lw_we  = 1'b1;
                     tbl_wr.lw     = job_ff;
                     tbl_wr.cnt_we = 1'b1;
                     tbl_wr.cnt    = '0;
                  end
                  rhet_pkg::ACT_ORDER: begin
                     if (other_ff != job_ff) begin
                        rsp_ev_in   = 1'b1;
                        rsp_from_in = other_ff;
                        rsp_to_in   = job_ff;
                     end
                  end
                  default: begin
                     tbl_wr.clear = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            // one edge is held back so the final one can carry last
            priority if (self_edge) begin
               if (walk_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  list_raddr = {res_ff, idx_ff + 1'b1};
               end
            end else if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  out_load    = 1'b1;
                  rsp_ev_in   = 1'b1;
                  rsp_from_in = pend_job_ff;
                  rsp_to_in   = job_ff;
                  rsp_last_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_job_in   = list_rdata;
               if (walk_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  list_raddr = {res_ff, idx_ff + 1'b1};
               end
            end else begin
               // stalled: keep the same slot on the read port
               list_raddr = {res_ff, idx_ff};
            end
         end
         S_FIN: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (pend_valid_ff) begin
                  rsp_ev_in   = 1'b1;
                  rsp_from_in = pend_job_ff;
                  rsp_to_in   = job_ff;
               end
               pend_valid_in = 1'b0;
               tbl_wr.lw_we  = 1'b1;
               tbl_wr.lw     = job_ff;
               tbl_wr.cnt_we = 1'b1;
               tbl_wr.cnt    = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      job_ff      <= job_in;
      res_ff      <= res_in;
      other_ff    <= other_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pend_job_ff <= pend_job_in;
      if (out_load) begin
         rsp_ev_ff   <= rsp_ev_in;
         rsp_from_ff <= rsp_from_in;
         rsp_to_ff   <= rsp_to_in;
         rsp_ovf_ff  <= rsp_ovf_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_edge_valid      = rsp_ev_ff;
   assign rsp_edge_from       = rsp_from_ff;
   assign rsp_edge_to         = rsp_to_ff;
   assign rsp_reader_overflow = rsp_ovf_ff;
   assign rsp_last            = rsp_last_ff;

   // walk never reaches past the stored reader count
   `RHET_ASSERT_IMPL(a_walk_in_range, state_ff == S_WALK, rhet_pkg::cnt_type'(idx_ff) < cnt_ff)
   // one request at a time
   `RHET_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)
   // self edges never leave the block
   `RHET_ASSERT_IMPL(a_no_self_edge, rsp_valid && rsp_edge_valid, rsp_edge_from != rsp_edge_to)
   // an empty beat carries zero job fields
   `RHET_ASSERT_IMPL(a_empty_beat_zero, rsp_valid && !rsp_edge_valid, rsp_edge_from == '0 && rsp_edge_to == '0 && rsp_last)
   // overflow only flagged on the single beat of a read
   `RHET_ASSERT_IMPL(a_ovf_is_last, rsp_valid && rsp_reader_overflow, rsp_last)

endmodule

[hw/rtl/rhet_res_table.sv]
// per-resource table: last writer, reader count and their valid bits
// depends on rhet_pkg
module rhet_res_table (
   input  logic                clock,
   input  logic                reset,
   input  rhet_pkg::res_type   rd_addr,
   input  rhet_pkg::tbl_wr_type wr,
   output rhet_pkg::tbl_rd_type rd
);

   logic [rhet_pkg::NUM_RESOURCES-1:0] wv_ff, wv_in;
   logic [rhet_pkg::NUM_RESOURCES-1:0] cv_ff, cv_in;

   rhet_pkg::job_type lw_mem_ff  [rhet_pkg::NUM_RESOURCES];
   rhet_pkg::cnt_type cnt_mem_ff [rhet_pkg::NUM_RESOURCES];

   rhet_pkg::job_type lw_q_ff;
   rhet_pkg::cnt_type cnt_q_ff;
   logic              wv_q_ff;
   logic              cv_q_ff;

   // valid bits stand in for the reset value of both arrays
   always_comb begin
      wv_in = wv_ff;
      cv_in = cv_ff;
      if (wr.clear) begin
         wv_in = '0;
         cv_in = '0;
      end else begin
         if (wr.lw_we) begin
            wv_in[wr.addr] = 1'b1;
         end
         if (wr.cnt_we) begin
            cv_in[wr.addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= '0;
         cv_ff <= '0;
      end else begin
         wv_ff <= wv_in;
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.lw_we) begin
         lw_mem_ff[wr.addr] <= wr.lw;
      end
      if (wr.cnt_we) begin
         cnt_mem_ff[wr.addr] <= wr.cnt;
      end
      lw_q_ff  <= lw_mem_ff[rd_addr];
      cnt_q_ff <= cnt_mem_ff[rd_addr];
      wv_q_ff  <= wv_ff[rd_addr];
      cv_q_ff  <= cv_ff[rd_addr];
   end

   assign rd.wv  = wv_q_ff;
   assign rd.lw  = lw_q_ff;
   assign rd.cnt = cv_q_ff ? cnt_q_ff : '0;

endmodule

[hw/rtl/rhet_reader_ram.sv]
// reader list storage, one row of slots per resource, registered read
// depends on rhet_pkg
module rhet_reader_ram (
   input  logic                    clock,
   input  logic                    we,
   input  rhet_pkg::list_addr_type waddr,
   input  rhet_pkg::job_type       wdata,
   input  rhet_pkg::list_addr_type raddr,
   output rhet_pkg::job_type       rdata
);

   rhet_pkg::job_type mem_ff [2**rhet_pkg::LIST_AW];
   rhet_pkg::job_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
